/* rtl/tbgd_pkg.sv */
package tbgd_pkg;

  localparam int SCORE_W = 16;
  localparam int DIST_W  = 16;
  localparam int ANGLE_W = 15;
  localparam int POS_W   = 10;
  localparam int COORD_W = 12;
  localparam int SIZE_W  = 13;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Q.30 CORDIC datapath, one guard bit above the sign
  localparam int CD_W = 33;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 64;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 15'sd12868;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -15'sd12868;
  localparam logic signed [CD_W-1:0]    CORDIC_GAIN = 33'sd652032874;
  localparam logic [COORD_W-1:0]        COORD_MAX = 12'd4095;

  localparam int ATAN_ENTRIES = 24;
  localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCORE_THRESHOLD = 2'd0,
    REG_IMAGE_WIDTH     = 2'd1,
    REG_IMAGE_HEIGHT    = 2'd2,
    REG_UNUSED          = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [DIST_W-1:0]  dist_top;
    logic [DIST_W-1:0]  dist_right;
    logic [DIST_W-1:0]  dist_bottom;
    logic [DIST_W-1:0]  dist_left;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
  } cell_info_t;

  typedef struct packed {
    logic signed [CD_W-1:0] x;
    logic signed [CD_W-1:0] y;
    logic signed [CD_W-1:0] z;
    cell_info_t             info;
  } cordic_t;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [SCORE_W-1:0] score;
  } box_t;

endpackage

/* rtl/text_box_geometry_decode_core.sv */
// Text box geometry decoder: one feature-map cell in, at most one box out.
// Slave stream: one cell per item on s_axis_tdata; cells scoring below
// score_threshold are dropped inside the pipeline and give no output item.
// Master stream: one box per item on m_axis_tdata.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 score_threshold, 1 image_width, 2 image_height). Write only while the
// block is idle; the block itself does not enforce this.
// Registers: input, one CORDIC cell per stage, multiply, sum, output.
// Throughput: one cell per cycle unless stalled; the CORDIC cell chain, the
// multiply and the sum stages each hold one item and advance together.
// Stall: when the receiver holds m_axis_tready low, the next finished box is
// caught in a one-entry skid register and the whole pipeline freezes, so
// s_axis_tready drops in the next cycle and rises again once the skid drains.
// Reset: all pipeline valid bits and both output valid bits clear, registers
// return to threshold 32768, width 1920, height 1024.
module text_box_geometry_decode_core #(
  parameter int CELL_STRIDE   = 4,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // cell_score[15:0], dist_top[31:16], dist_right[47:32], dist_bottom[63:48],
  // dist_left[79:64], rotation[94:80], cell_col[104:95], cell_row[114:105]
  input  logic [tbgd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // box_start_x[11:0], box_start_y[23:12], box_end_x[35:24], box_end_y[47:36],
  // box_score[63:48]
  output logic [tbgd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we_i,
  input  logic [tbgd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tbgd_pkg::CFG_W-1:0]        cfg_wdata_i
);
  import tbgd_pkg::*;

  // configuration registers
  logic [SCORE_W-1:0] thr_q;
  logic [SIZE_W-1:0]  width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= 16'd32768;
      width_q  <= 13'd1920;
      height_q <= 13'd1024;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SCORE_THRESHOLD: thr_q    <= cfg_wdata_i;
        REG_IMAGE_WIDTH:     width_q  <= cfg_wdata_i[SIZE_W-1:0];
        REG_IMAGE_HEIGHT:    height_q <= cfg_wdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances while the skid register is empty
  logic en;
  logic skid_vq;
  box_t skid_q;
  logic out_vq;
  box_t out_q;

  assign en            = !skid_vq;
  assign s_axis_tready = en;

  // input stage: threshold check and angle clamp
  logic                       in_acc;
  cell_info_t                 in_info;
  logic signed [ANGLE_W-1:0]  rot, rot_c;
  cordic_t                    in_d;
  logic                       in_vq;
  cordic_t                    in_q;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_info.score       = s_axis_tdata[15:0];
    in_info.dist_top    = s_axis_tdata[31:16];
    in_info.dist_right  = s_axis_tdata[47:32];
    in_info.dist_bottom = s_axis_tdata[63:48];
    in_info.dist_left   = s_axis_tdata[79:64];
    rot                 = $signed(s_axis_tdata[94:80]);
    in_info.col         = s_axis_tdata[104:95];
    in_info.row         = s_axis_tdata[114:105];
    priority if (rot > ANGLE_MAX) begin
      rot_c = ANGLE_MAX;
    end else if (rot < ANGLE_MIN) begin
      rot_c = ANGLE_MIN;
    end else begin
      rot_c = rot;
    end
    in_d.x    = CORDIC_GAIN;
    in_d.y    = '0;
    in_d.z    = $signed({{(CD_W-ANGLE_W-17){rot_c[ANGLE_W-1]}}, rot_c, 17'd0});
    in_d.info = in_info;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (en) begin
      in_vq <= in_acc && (in_info.score >= thr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_d;
    end
  end

  // CORDIC cell chain
  logic    chain_v [CORDIC_STAGES+1];
  cordic_t chain_d [CORDIC_STAGES+1];

  assign chain_v[0] = in_vq;
  assign chain_d[0] = in_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    tbgd_cordic_cell #(
      .STAGE (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_v[g]),
      .data_i  (chain_d[g]),
      .valid_o (chain_v[g+1]),
      .data_o  (chain_d[g+1])
    );
  end

  logic geom_v;
  box_t geom_box;

  tbgd_geom #(
    .CELL_STRIDE (CELL_STRIDE)
  ) u_geom (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (chain_v[CORDIC_STAGES]),
    .data_i         (chain_d[CORDIC_STAGES]),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .valid_o        (geom_v),
    .box_o          (geom_box)
  );

  // output register with skid
  logic push;
  assign push = en && geom_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      skid_vq <= 1'b0;
    end else if (out_vq && !m_axis_tready) begin
      if (push) begin
        skid_vq <= 1'b1;
      end
    end else if (skid_vq) begin
      out_vq  <= 1'b1;
      skid_vq <= 1'b0;
    end else begin
      out_vq <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_vq && !m_axis_tready) begin
      if (push) begin
        skid_q <= geom_box;
      end
    end else if (skid_vq) begin
      out_q <= skid_q;
    end else if (push) begin
      out_q <= geom_box;
    end
  end

  assign m_axis_tvalid = out_vq;
  assign m_axis_tdata  = {out_q.score, out_q.end_y, out_q.end_x,
                          out_q.start_y, out_q.start_x};

endmodule

/* rtl/tbgd_cordic_cell.sv */
module tbgd_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  tbgd_pkg::cordic_t data_i,
  output logic              valid_o,
  output tbgd_pkg::cordic_t data_o
);
  import tbgd_pkg::*;

  logic signed [CD_W-1:0] xs, ys, atan;
  cordic_t data_d, data_q;
  logic    valid_q;

  always_comb begin
    xs     = data_i.x >>> STAGE;
    ys     = data_i.y >>> STAGE;
    atan   = $signed({1'b0, ATAN_Q30[STAGE]});
    data_d = data_i;
    // rotate toward zero residual angle
    if (!data_i.z[CD_W-1]) begin
      data_d.x = data_i.x - ys;
      data_d.y = data_i.y + xs;
      data_d.z = data_i.z - atan;
    end else begin
      data_d.x = data_i.x + ys;
      data_d.y = data_i.y - xs;
      data_d.z = data_i.z + atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/tbgd_geom.sv */
module tbgd_geom #(
  parameter int CELL_STRIDE = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  tbgd_pkg::cordic_t            data_i,
  input  logic [tbgd_pkg::SIZE_W-1:0]  image_width_i,
  input  logic [tbgd_pkg::SIZE_W-1:0]  image_height_i,
  output logic                         valid_o,
  output tbgd_pkg::box_t               box_o
);
  import tbgd_pkg::*;

  localparam int STRIDE_W = $clog2(CELL_STRIDE + 1);
  localparam int BASE_W   = POS_W + STRIDE_W;
  localparam int PROD_W   = CD_W + DIST_W + 1;
  localparam int SUM_W    = BASE_W + 35 + 2;
  localparam int END_W    = BASE_W + 1;
  localparam int LEN_W    = DIST_W + 1;

  // multiply stage
  logic                     mul_vq;
  logic signed [PROD_W-1:0] cr_q, cb_q, sr_q, sb_q;
  logic [BASE_W-1:0]        bx_q, by_q;
  logic [COORD_W-1:0]       lw_q, lh_q;
  logic [SCORE_W-1:0]       ms_q;
  logic [LEN_W-1:0]         sum_w, sum_h;

  assign sum_w = LEN_W'(data_i.info.dist_right) + LEN_W'(data_i.info.dist_left);
  assign sum_h = LEN_W'(data_i.info.dist_top) + LEN_W'(data_i.info.dist_bottom);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vq <= 1'b0;
    end else if (en_i) begin
      mul_vq <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cr_q <= data_i.x * $signed({1'b0, data_i.info.dist_right});
      cb_q <= data_i.x * $signed({1'b0, data_i.info.dist_bottom});
      sr_q <= data_i.y * $signed({1'b0, data_i.info.dist_right});
      sb_q <= data_i.y * $signed({1'b0, data_i.info.dist_bottom});
      bx_q <= BASE_W'(data_i.info.col) * BASE_W'(CELL_STRIDE);
      by_q <= BASE_W'(data_i.info.row) * BASE_W'(CELL_STRIDE);
      lw_q <= sum_w[LEN_W-1:5];
      lh_q <= sum_h[LEN_W-1:5];
      ms_q <= data_i.info.score;
    end
  end

  // sum stage, truncated to whole pixels
  logic signed [SUM_W-1:0] ex, ey;
  logic [END_W-1:0]        px_d, py_d, px_q, py_q;
  logic [COORD_W-1:0]      lw2_q, lh2_q;
  logic [SCORE_W-1:0]      ss_q;
  logic                    sum_vq;

  always_comb begin
    ex = $signed({2'b00, bx_q, 35'd0}) + SUM_W'(cr_q) + SUM_W'(sb_q);
    ey = $signed({2'b00, by_q, 35'd0}) - SUM_W'(sr_q) + SUM_W'(cb_q);
    px_d = ex[SUM_W-1] ? '0 : ex[SUM_W-2:35];
    py_d = ey[SUM_W-1] ? '0 : ey[SUM_W-2:35];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vq <= 1'b0;
    end else if (en_i) begin
      sum_vq <= mul_vq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q  <= px_d;
      py_q  <= py_d;
      lw2_q <= lw_q;
      lh2_q <= lh_q;
      ss_q  <= ms_q;
    end
  end

  // clamp end to image size minus one, saturate start at zero and top
  logic [SIZE_W-1:0]  lim_x13, lim_y13;
  logic [COORD_W-1:0] lim_x, lim_y;
  logic [END_W-1:0]   dx, dy;

  always_comb begin
    lim_x13 = (image_width_i == '0) ? '0 : image_width_i - SIZE_W'(1);
    lim_y13 = (image_height_i == '0) ? '0 : image_height_i - SIZE_W'(1);
    lim_x   = (lim_x13 > SIZE_W'(COORD_MAX)) ? COORD_MAX : lim_x13[COORD_W-1:0];
    lim_y   = (lim_y13 > SIZE_W'(COORD_MAX)) ? COORD_MAX : lim_y13[COORD_W-1:0];
    dx      = (px_q > END_W'(lw2_q)) ? px_q - END_W'(lw2_q) : '0;
    dy      = (py_q > END_W'(lh2_q)) ? py_q - END_W'(lh2_q) : '0;
    box_o.start_x = (dx > END_W'(COORD_MAX)) ? COORD_MAX : dx[COORD_W-1:0];
    box_o.start_y = (dy > END_W'(COORD_MAX)) ? COORD_MAX : dy[COORD_W-1:0];
    box_o.end_x   = (px_q > END_W'(lim_x)) ? lim_x : px_q[COORD_W-1:0];
    box_o.end_y   = (py_q > END_W'(lim_y)) ? lim_y : py_q[COORD_W-1:0];
    box_o.score   = ss_q;
  end

  assign valid_o = sum_vq;

endmodule

/* verif/text_box_geometry_decode_core_tb.sv */
`timescale 1ns / 1ps

module text_box_geometry_decode_core_tb;
  import tbgd_pkg::*;

  localparam int STRIDE      = 4;
  localparam int STAGES      = 16;
  localparam int DRAIN_WAIT  = 2 * (STAGES + 4);
  localparam int HOLD_CYCLES = 300;
  localparam longint ANG_LIMIT = 12868;
  localparam longint GAIN_Q30  = 652032874;
  localparam longint ATAN_STEP [STAGES] = '{
    843314857, 497837829, 263043837, 133525159,
    67021687,  33543516,  16775851,  8388437,
    4194283,   2097149,   1048576,   524288,
    262144,    131072,    65536,     32768
  };

  typedef struct {
    logic [SCORE_W-1:0]        score;
    logic [DIST_W-1:0]         dist_top;
    logic [DIST_W-1:0]         dist_right;
    logic [DIST_W-1:0]         dist_bottom;
    logic [DIST_W-1:0]         dist_left;
    logic signed [ANGLE_W-1:0] rotation;
    logic [POS_W-1:0]          col;
    logic [POS_W-1:0]          row;
  } cell_t;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_W-1:0]      cfg_wdata_i = '0;

  // register shadows for the box predictor
  logic [SCORE_W-1:0] score_thr = 16'd32768;
  logic [SIZE_W-1:0]  img_w     = 13'd1920;
  logic [SIZE_W-1:0]  img_h     = 13'd1024;

  cell_t cells_pending[$];
  box_t  boxes_expected[$];
  int    cells_sent     = 0;
  int    cells_accepted = 0;
  int    mismatches     = 0;
  int    src_gap_max    = 0;
  int    rx_stall_max   = 0;
  int    gap_left       = 0;
  int    stall_left     = 0;
  bit    hold_armed     = 1'b0;
  logic  rx_blocked     = 1'b0;

  text_box_geometry_decode_core #(
    .CELL_STRIDE  (STRIDE),
    .CORDIC_STAGES(STAGES)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [IN_DATA_W-1:0] pack_cell(cell_t c);
    return {5'b0, c.row, c.col, c.rotation, c.dist_left, c.dist_bottom, c.dist_right,
            c.dist_top, c.score};
  endfunction

  function automatic longint whole_px(longint v);
    return (v < 0) ? 64'sd0 : (v >>> 35);
  endfunction

  function automatic logic [COORD_W-1:0] start_px(longint end_v, longint len);
    longint v;
    v = (end_v > len) ? end_v - len : 64'sd0;
    return (v > 4095) ? COORD_MAX : COORD_W'(v);
  endfunction

  function automatic logic [COORD_W-1:0] clamp_px(longint end_v, logic [SIZE_W-1:0] size);
    longint lim;
    lim = (size == 0) ? 64'sd0 : longint'(size) - 1;
    if (lim > 4095) lim = 4095;
    return COORD_W'((end_v > lim) ? lim : end_v);
  endfunction

  // Returns 1 when the cell yields a box, with the box it yields.
  function automatic bit decode_cell(input cell_t ci, output box_t box);
    longint ang, x, y, z, xs, ys, dr, db, dt, dl, ex, ey, end_x, end_y;
    box = '0;
    if (ci.score < score_thr) return 1'b0;
    ang = longint'(ci.rotation);
    if (ang > ANG_LIMIT) ang = ANG_LIMIT;
    if (ang < -ANG_LIMIT) ang = -ANG_LIMIT;
    x = GAIN_Q30;
    y = 0;
    z = ang * 131072;
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_STEP[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_STEP[i];
      end
    end
    dt = longint'(ci.dist_top);
    dr = longint'(ci.dist_right);
    db = longint'(ci.dist_bottom);
    dl = longint'(ci.dist_left);
    // x holds cosine and y sine, both Q.30; products land in Q.35
    ex = longint'(ci.col) * STRIDE * (64'sd1 <<< 35) + x * dr + y * db;
    ey = longint'(ci.row) * STRIDE * (64'sd1 <<< 35) - y * dr + x * db;
    end_x = whole_px(ex);
    end_y = whole_px(ey);
    box.start_x = start_px(end_x, (dr + dl) >>> 5);
    box.start_y = start_px(end_y, (dt + db) >>> 5);
    box.end_x   = clamp_px(end_x, img_w);
    box.end_y   = clamp_px(end_y, img_h);
    box.score   = ci.score;
    return 1'b1;
  endfunction

  function automatic cell_t make_cell(logic [15:0] score, logic [15:0] dt, logic [15:0] dr,
                                      logic [15:0] db, logic [15:0] dl,
                                      logic signed [14:0] rot, logic [9:0] col,
                                      logic [9:0] row);
    cell_t c;
    c.score       = score;
    c.dist_top    = dt;
    c.dist_right  = dr;
    c.dist_bottom = db;
    c.dist_left   = dl;
    c.rotation    = rot;
    c.col         = col;
    c.row         = row;
    return c;
  endfunction

  function automatic logic [DIST_W-1:0] random_dist();
    return ($urandom_range(0, 4) == 0) ? DIST_W'($urandom) : DIST_W'($urandom_range(0, 2047));
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    if ($urandom_range(0, 9) < 7) c.score = SCORE_W'($urandom_range(65535, 32'(score_thr)));
    else c.score = SCORE_W'($urandom);
    c.dist_top    = random_dist();
    c.dist_right  = random_dist();
    c.dist_bottom = random_dist();
    c.dist_left   = random_dist();
    if ($urandom_range(0, 4) == 0) c.rotation = ANGLE_W'($urandom);
    else c.rotation = ANGLE_W'(int'($urandom_range(0, 25736)) - 12868);
    c.col = POS_W'($urandom);
    c.row = POS_W'($urandom);
    return c;
  endfunction

  task automatic send_cell(cell_t c);
    cells_pending.push_back(c);
    cells_sent++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SCORE_THRESHOLD: score_thr = val;
      REG_IMAGE_WIDTH:     img_w     = val[SIZE_W-1:0];
      REG_IMAGE_HEIGHT:    img_h     = val[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [CFG_W-1:0] thr, logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    write_reg(REG_SCORE_THRESHOLD, thr);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  // Dropped cells leave no trace, so wait out the pipeline after the last box.
  task automatic wait_idle();
    while (cells_accepted != cells_sent || boxes_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic run_random(int count, int src_max, int rx_max);
    src_gap_max  = src_max;
    rx_stall_max = rx_max;
    repeat (count) send_cell(random_cell());
    wait_idle();
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // cell driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) gap_left = $urandom_range(0, src_gap_max);
      if (gap_left == 0 && cells_pending.size() != 0) begin
        s_axis_tdata  <= pack_cell(cells_pending.pop_front());
        s_axis_tvalid <= 1'b1;
      end else begin
        if (gap_left > 0) gap_left--;
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // predict a box for each accepted cell that meets the threshold
  always @(posedge clk_i) begin
    cell_t c;
    box_t  b;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      c.score       = s_axis_tdata[15:0];
      c.dist_top    = s_axis_tdata[31:16];
      c.dist_right  = s_axis_tdata[47:32];
      c.dist_bottom = s_axis_tdata[63:48];
      c.dist_left   = s_axis_tdata[79:64];
      c.rotation    = s_axis_tdata[94:80];
      c.col         = s_axis_tdata[104:95];
      c.row         = s_axis_tdata[114:105];
      if (decode_cell(c, b)) boxes_expected.push_back(b);
      cells_accepted++;
    end
  end

  // box receiver and checker
  always @(posedge clk_i) begin
    box_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (boxes_expected.size() == 0) begin
          $error("box item with none expected: %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = boxes_expected.pop_front();
          check_field("box_start_x", want.start_x, m_axis_tdata[11:0]);
          check_field("box_start_y", want.start_y, m_axis_tdata[23:12]);
          check_field("box_end_x", want.end_x, m_axis_tdata[35:24]);
          check_field("box_end_y", want.end_y, m_axis_tdata[47:36]);
          check_field("box_score", want.score, m_axis_tdata[63:48]);
        end
        stall_left = $urandom_range(0, rx_stall_max);
      end
      if (rx_blocked) begin
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the pipeline backs up into the input
  initial begin
    wait (hold_armed);
    @(posedge clk_i);
    rx_blocked <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_blocked <= 1'b0;
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: threshold edge, angle limits, coordinate saturation
    src_gap_max  = 3;
    rx_stall_max = 3;
    send_cell(make_cell(16'd32768, 16'd320, 16'd320, 16'd320, 16'd320, 15'sd0, 10'd10, 10'd10));
    send_cell(make_cell(16'd32767, 16'd320, 16'd320, 16'd320, 16'd320, 15'sd0, 10'd10, 10'd10));
    send_cell(make_cell(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 15'sd0, 10'd0, 10'd0));
    send_cell(make_cell(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 15'sd0, 10'd0, 10'd0));
    send_cell(make_cell(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'sd0,
                        10'd1023, 10'd1023));
    // start beyond 4095: diagonal box far down the map
    send_cell(make_cell(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 15'sd6434,
                        10'd1023, 10'd1023));
    send_cell(make_cell(16'hFFFF, 16'd500, 16'd3000, 16'd2000, 16'd700, ANGLE_MAX,
                        10'd0, 10'd0));
    send_cell(make_cell(16'hFFFF, 16'd500, 16'd3000, 16'd2000, 16'd700, ANGLE_MIN,
                        10'd0, 10'd0));
    send_cell(make_cell(16'hFFFF, 16'd500, 16'd3000, 16'd2000, 16'd700, 15'sh3FFF,
                        10'd300, 10'd200));
    send_cell(make_cell(16'hFFFF, 16'd500, 16'd3000, 16'd2000, 16'd700, 15'sh4000,
                        10'd300, 10'd200));
    send_cell(make_cell(16'hFFFF, 16'd500, 16'd3000, 16'd2000, 16'd700, 15'sh3245,
                        10'd300, 10'd200));
    // start clipped at zero: short end, wide box
    send_cell(make_cell(16'hFFFF, 16'hF000, 16'd64, 16'd64, 16'hF000, 15'sd0, 10'd0, 10'd0));
    send_cell(make_cell(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 15'sh2AAA,
                        10'h2AA, 10'h2AA));
    send_cell(make_cell(16'hD555, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 15'sh5555,
                        10'h155, 10'h155));
    send_cell(make_cell(16'hFFFF, 16'd1000, 16'd1000, 16'd1000, 16'd1000, 15'sd100,
                        10'd1023, 10'd0));
    send_cell(make_cell(16'hFFFF, 16'd1000, 16'd1000, 16'd1000, 16'd1000, -15'sd100,
                        10'd0, 10'd1023));
    wait_idle();

    // zero image size clamps both ends to 0
    configure(16'd100, 16'd0, 16'd0);
    send_cell(make_cell(16'd100, 16'd900, 16'd900, 16'd900, 16'd900, 15'sd0, 10'd50, 10'd60));
    send_cell(make_cell(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'sd3000,
                        10'd1023, 10'd1023));
    send_cell(make_cell(16'd99, 16'd900, 16'd900, 16'd900, 16'd900, 15'sd0, 10'd50, 10'd60));
    run_random(30, 14, 14);

    configure(16'd0, 16'd4096, 16'd4096);
    run_random(80, 14, 0);

    configure(16'hFFFF, 16'd1, 16'd1);
    run_random(60, 0, 14);

    configure(16'd0, 16'h1FFF, 16'd1);
    run_random(40, 5, 5);

    // back-pressure: steady input while the receiver is held off
    src_gap_max  = 0;
    rx_stall_max = 0;
    repeat (120) send_cell(random_cell());
    hold_armed = 1'b1;
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      configure(CFG_W'($urandom_range(0, 49152)), CFG_W'($urandom_range(1, 4096)),
                CFG_W'($urandom_range(1, 4096)));
      run_random(45, (p % 2 == 0) ? 14 : 0, (p < 2) ? 14 : 2);
    end

    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
